// ----- sv/omsl_pkg.sv -----
// Shared types, register codes and arithmetic helpers of the omni base slew limiter and mixer.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package omsl_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_X      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_W      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_COEF    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_RADIUS = 3'd5;

  localparam logic [1:0] MODE_MANUAL = 2'd0;

  localparam logic [14:0] STEP_RESET   = 15'd64;
  localparam logic [14:0] COS_RESET    = 15'd23170;
  localparam logic [15:0] RADIUS_RESET = 16'd16384;

  typedef struct packed {
    logic [1:0]  drive_mode;
    logic [14:0] step_x;
    logic [14:0] step_y;
    logic [14:0] step_w;
    logic [14:0] cos_coef;
    logic [15:0] base_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
  } lim_t;

  function automatic logic signed [15:0] slew(input logic signed [15:0] target,
                                              input logic signed [15:0] last,
                                              input logic [16:0] step);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    logic signed [15:0] res;
    diff = {target[15], target} - {last[15], last};
    mag  = diff[16] ? 17'(-diff) : 17'(diff);
    up   = {{2{last[15]}}, last} + {1'b0, step};
    dn   = {{2{last[15]}}, last} - {1'b0, step};
    if (mag > step) begin
      res = (last > target) ? dn[15:0] : up[15:0];
    end else begin
      res = target;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
    logic signed [17:0] res;
    if (v > 19'sd131071) begin
      res = 18'sd131071;
    end else if (v < -19'sd131072) begin
      res = -18'sd131072;
    end else begin
      res = v[17:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/omsl_ifs.sv -----
// Valid/ready channel interfaces of the omni base slew limiter and mixer.
// Depends on omsl_pkg for the register index width and the limited velocity type.
`default_nettype none

interface omsl_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vx_command;
  logic signed [15:0] vy_command;
  logic signed [15:0] w_command;
  modport source (output valid, vx_command, vy_command, w_command, input ready);
  modport sink (input valid, vx_command, vy_command, w_command, output ready);
endinterface

interface omsl_lim_if;
  logic                valid;
  logic                ready;
  omsl_pkg::lim_t      data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface omsl_res_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] front_left_speed;
  logic signed [17:0] front_right_speed;
  logic signed [17:0] back_right_speed;
  logic signed [17:0] back_left_speed;
  logic signed [15:0] limited_vx;
  logic signed [15:0] limited_vy;
  logic signed [15:0] limited_w;
  modport source (output valid, front_left_speed, front_right_speed, back_right_speed,
                  back_left_speed, limited_vx, limited_vy, limited_w, input ready);
  modport sink (input valid, front_left_speed, front_right_speed, back_right_speed,
                back_left_speed, limited_vx, limited_vy, limited_w, output ready);
endinterface

interface omsl_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [omsl_pkg::CFG_INDEX_W-1:0]      index;
  logic [omsl_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/omsl_front.sv -----
// Front end: accepts command items, picks targets by drive mode and slew limits each axis.
// Holds the previous limited velocities. Depends on omsl_pkg and omsl_ifs.
`default_nettype none

module omsl_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire omsl_pkg::cfg_t cfg,
  omsl_cmd_if.sink            cmd,
  omsl_lim_if.source          lim
);

  logic signed [15:0] prev_vx;
  logic signed [15:0] prev_vy;
  logic signed [15:0] prev_w;
  logic signed [15:0] tx;
  logic signed [15:0] ty;
  logic signed [15:0] tw;
  logic               all_zero;
  logic [16:0]        sx;
  logic [16:0]        sy;
  logic [16:0]        sw;
  logic               accept;

  always_comb begin
    if (cfg.drive_mode == omsl_pkg::MODE_MANUAL) begin
      tx = cmd.vx_command;
      ty = cmd.vy_command;
      tw = cmd.w_command;
    end else begin
      tx = prev_vx;
      ty = prev_vy;
      tw = prev_w;
    end
    all_zero = (tx == '0) && (ty == '0) && (tw == '0);
    if (all_zero) begin
      sx = {1'b0, cfg.step_x, 1'b0};
      sy = {1'b0, cfg.step_y, 1'b0};
      sw = {2'b00, cfg.step_w} + {3'b000, cfg.step_w[14:1]};
    end else begin
      sx = {2'b00, cfg.step_x};
      sy = {2'b00, cfg.step_y};
      sw = {2'b00, cfg.step_w};
    end
  end

  assign lim.data.vx = omsl_pkg::slew(tx, prev_vx, sx);
  assign lim.data.vy = omsl_pkg::slew(ty, prev_vy, sy);
  assign lim.data.w  = omsl_pkg::slew(tw, prev_w, sw);
  assign lim.valid   = cmd.valid;
  assign cmd.ready   = lim.ready;
  assign accept      = cmd.valid && lim.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vx <= '0;
      prev_vy <= '0;
      prev_w  <= '0;
    end else if (accept) begin
      prev_vx <= lim.data.vx;
      prev_vy <= lim.data.vy;
      prev_w  <= lim.data.w;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (prev_vx == '0) && (prev_vy == '0) && (prev_w == '0))
    else $error("Previous velocities not cleared by reset.");

  a_hold_modes: assert property (@(posedge clk) disable iff (rst)
    (accept && (cfg.drive_mode != omsl_pkg::MODE_MANUAL))
      |=> $stable(prev_vx) && $stable(prev_vy) && $stable(prev_w))
    else $error("Velocity moved in a holding mode.");

  a_idle_keeps: assert property (@(posedge clk)
    (!rst && !accept) |=> $stable(prev_vx) && $stable(prev_vy) && $stable(prev_w))
    else $error("Velocity changed without an accepted item.");
`endif

endmodule

`default_nettype wire

// ----- sv/omsl_queue.sv -----
// Short queue of limited velocity items between the front end and the mixer.
// Depends on omsl_pkg and omsl_ifs.
`default_nettype none

module omsl_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  omsl_lim_if.sink   wr,
  omsl_lim_if.source rd
);

  localparam int unsigned PTR_W = (omsl_pkg::QUEUE_DEPTH > 1) ? $clog2(omsl_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(omsl_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(omsl_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(omsl_pkg::QUEUE_DEPTH - 1);

  omsl_pkg::lim_t   mem [omsl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != FULL_CNT);
  assign rd.valid = (count != '0);
  assign rd.data  = mem[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/omsl_back.sv -----
// Back end: mixes limited velocities into four omni wheel speeds in two registered stages.
// Stage one holds the truncated products, stage two the saturated sums. Depends on omsl_pkg, omsl_ifs.
`default_nettype none

module omsl_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire omsl_pkg::cfg_t cfg,
  omsl_lim_if.sink            lim,
  omsl_res_if.source          res
);

  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic signed [32:0] prod_w;
  logic               s1_valid;
  logic signed [15:0] term_a;
  logic signed [15:0] term_b;
  logic signed [15:0] term_r;
  omsl_pkg::lim_t     s1_lim;
  logic               out_valid;
  logic               adv_out;
  logic signed [18:0] sum_fl;
  logic signed [18:0] sum_fr;
  logic signed [18:0] sum_br;
  logic signed [18:0] sum_bl;
  logic signed [17:0] fl;
  logic signed [17:0] fr;
  logic signed [17:0] br;
  logic signed [17:0] bl;
  omsl_pkg::lim_t     out_lim;

  assign prod_x = $signed({{16{lim.data.vx[15]}}, lim.data.vx}) *
                  $signed({17'd0, cfg.cos_coef});
  assign prod_y = $signed({{16{lim.data.vy[15]}}, lim.data.vy}) *
                  $signed({17'd0, cfg.cos_coef});
  assign prod_w = $signed({{17{lim.data.w[15]}}, lim.data.w}) *
                  $signed({17'd0, cfg.base_radius});

  assign adv_out   = !out_valid || res.ready;
  assign lim.ready = !s1_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (lim.ready) begin
        s1_valid <= lim.valid;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lim.valid && lim.ready) begin
      term_a <= prod_x[30:15];
      term_b <= prod_y[30:15];
      term_r <= prod_w[31:16];
      s1_lim <= lim.data;
    end
  end

  always_comb begin
    sum_fl = 19'(term_b) + 19'(term_a) - 19'(term_r);
    sum_fr = -19'(term_b) + 19'(term_a) - 19'(term_r);
    sum_br = -19'(term_b) - 19'(term_a) - 19'(term_r);
    sum_bl = 19'(term_b) - 19'(term_a) - 19'(term_r);
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      fl      <= omsl_pkg::sat18(sum_fl);
      fr      <= omsl_pkg::sat18(sum_fr);
      br      <= omsl_pkg::sat18(sum_br);
      bl      <= omsl_pkg::sat18(sum_bl);
      out_lim <= s1_lim;
    end
  end

  assign res.valid             = out_valid;
  assign res.front_left_speed  = fl;
  assign res.front_right_speed = fr;
  assign res.back_right_speed  = br;
  assign res.back_left_speed   = bl;
  assign res.limited_vx        = out_lim.vx;
  assign res.limited_vy        = out_lim.vy;
  assign res.limited_w         = out_lim.w;

endmodule

`default_nettype wire

// ----- sv/omni_base_slew_limit_mixer_unit.sv -----
// Top level of the omni base slew limiter and mixer: configuration registers and the
// front end, queue and mixer. Depends on omsl_pkg, omsl_ifs and the omsl modules.
//
// Usage: each item on cmd is one control tick with commanded vx, vy and w. The block
// slew limits the three velocities against the values left by the previous item and
// returns one item on res with four wheel speeds and the limited velocities.
// Registers are written on cfg (index, data), which is always ready; write only while
// no item is in flight.
// A command item passes through the queue, the product stage and the sum stage before its result shows on res.
// Throughput: one item per cycle while res is ready; the front end finishes an item in the cycle it is
// accepted, and the mixer is a two-stage pipeline with one multiplier per product.
// Stalls: a two-entry queue separates front end and mixer, so the front end keeps
// accepting while a finished result waits on res; once the queue and both mixer
// stages are full, cmd.ready drops until res is taken.
// Reset: synchronous; clears the previous velocities to zero, restores the register
// defaults and empties the queue and pipeline.
`default_nettype none

module omni_base_slew_limit_mixer_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  omsl_cfg_if.sink   cfg,
  omsl_cmd_if.sink   cmd,
  omsl_res_if.source res
);

  omsl_pkg::cfg_t regs;

  omsl_lim_if front_lim ();
  omsl_lim_if back_lim ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.drive_mode  <= omsl_pkg::MODE_MANUAL;
      regs.step_x      <= omsl_pkg::STEP_RESET;
      regs.step_y      <= omsl_pkg::STEP_RESET;
      regs.step_w      <= omsl_pkg::STEP_RESET;
      regs.cos_coef    <= omsl_pkg::COS_RESET;
      regs.base_radius <= omsl_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        omsl_pkg::REG_DRIVE_MODE:  regs.drive_mode  <= cfg.data[1:0];
        omsl_pkg::REG_STEP_X:      regs.step_x      <= cfg.data[14:0];
        omsl_pkg::REG_STEP_Y:      regs.step_y      <= cfg.data[14:0];
        omsl_pkg::REG_STEP_W:      regs.step_w      <= cfg.data[14:0];
        omsl_pkg::REG_COS_COEF:    regs.cos_coef    <= cfg.data[14:0];
        omsl_pkg::REG_BASE_RADIUS: regs.base_radius <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  omsl_front u_front (
    .clk (clk),
    .rst (rst),
    .cfg (regs),
    .cmd (cmd),
    .lim (front_lim.source)
  );

  omsl_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_lim.sink),
    .rd  (back_lim.source)
  );

  omsl_back u_back (
    .clk (clk),
    .rst (rst),
    .cfg (regs),
    .lim (back_lim.sink),
    .res (res)
  );

endmodule

`default_nettype wire
